// ----- hw/rtl/jnum_pkg.sv -----
// Package: request types, character classes, parse phases and status codes.
`timescale 1ns / 1ps

package jnum_pkg;

    // Input request: end-of-text flag and one text byte
    typedef struct packed {
        logic       end_of_text;
        logic [7:0] text_byte;
    } in_req_t;

    // Result request
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] token_byte;
        logic [7:0] token_length;
    } out_req_t;

    // Character classes produced by the front end
    localparam logic [2:0] CL_EOT   = 3'd0;
    localparam logic [2:0] CL_ZERO  = 3'd1;
    localparam logic [2:0] CL_DIGIT = 3'd2;  // '1' .. '9'
    localparam logic [2:0] CL_MINUS = 3'd3;
    localparam logic [2:0] CL_PLUS  = 3'd4;
    localparam logic [2:0] CL_DOT   = 3'd5;
    localparam logic [2:0] CL_EXP   = 3'd6;  // 'e' or 'E'
    localparam logic [2:0] CL_OTHER = 3'd7;

    // Classified request carried through the queue
    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] text_byte;
    } cls_req_t;

    // Parse phases
    localparam logic [3:0] PH_SIGN      = 4'd0;
    localparam logic [3:0] PH_INT_FIRST = 4'd1;
    localparam logic [3:0] PH_INT       = 4'd2;
    localparam logic [3:0] PH_AFTER_INT = 4'd3;
    localparam logic [3:0] PH_DEC_FIRST = 4'd4;
    localparam logic [3:0] PH_DEC       = 4'd5;
    localparam logic [3:0] PH_EXP_SIGN  = 4'd6;
    localparam logic [3:0] PH_EXP_FIRST = 4'd7;
    localparam logic [3:0] PH_EXP       = 4'd8;

    // Status codes
    localparam logic [2:0] ST_CONSUMED = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_INT  = 3'd2;
    localparam logic [2:0] ST_BAD_DEC  = 3'd3;
    localparam logic [2:0] ST_BAD_EXP  = 3'd4;

    localparam int DEFAULT_MAX_TOKEN_LENGTH = 255;

endpackage

// ----- hw/rtl/jnum_front.sv -----
// Front end: classifies each incoming byte into a character class.
`timescale 1ns / 1ps

module jnum_front (
    input  jnum_pkg::in_req_t  in_req,
    output jnum_pkg::cls_req_t cls_req
);
    import jnum_pkg::*;

    logic [2:0] cls;

    always_comb begin
        if (in_req.end_of_text) begin
            cls = CL_EOT;
        end else if (in_req.text_byte == 8'h30) begin
            cls = CL_ZERO;
        end else if (in_req.text_byte inside {[8'h31:8'h39]}) begin
            cls = CL_DIGIT;
        end else if (in_req.text_byte == 8'h2D) begin
            cls = CL_MINUS;
        end else if (in_req.text_byte == 8'h2B) begin
            cls = CL_PLUS;
        end else if (in_req.text_byte == 8'h2E) begin
            cls = CL_DOT;
        end else if (in_req.text_byte inside {8'h65, 8'h45}) begin
            cls = CL_EXP;
        end else begin
            cls = CL_OTHER;
        end
    end

    assign cls_req.cls       = cls;
    assign cls_req.text_byte = in_req.text_byte;

endmodule

// ----- hw/rtl/jnum_queue.sv -----
// Two-entry queue between the classifier and the parser.
`timescale 1ns / 1ps

module jnum_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jnum_pkg::cls_req_t push_req,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output jnum_pkg::cls_req_t head_req
);
    import jnum_pkg::*;

    cls_req_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_req  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- hw/rtl/jnum_back.sv -----
// Back end: number grammar state machine, length counter and output register.
`timescale 1ns / 1ps

module jnum_back #(
    parameter int MAX_TOKEN_LENGTH = jnum_pkg::DEFAULT_MAX_TOKEN_LENGTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  jnum_pkg::cls_req_t q_req,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output jnum_pkg::out_req_t m_req
);
    import jnum_pkg::*;

    localparam int          LIMIT_INT   = (MAX_TOKEN_LENGTH > 255) ? 255 : MAX_TOKEN_LENGTH;
    localparam logic [7:0]  COUNT_LIMIT = 8'(LIMIT_INT);

    logic [3:0] phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic       valid_reg, valid_next;
    out_req_t   out_reg,   out_next;

    logic [3:0] step_phase;
    logic [2:0] step_status;
    logic [2:0] cls;

    assign cls    = q_req.cls;
    assign q_pop  = q_valid && (!valid_reg || m_ready);

    // Grammar: next phase and status for the head request
    always_comb begin
        step_phase  = phase_reg;
        step_status = ST_CONSUMED;
        case (phase_reg)
            PH_INT_FIRST: begin
                if (cls == CL_ZERO)       step_phase  = PH_AFTER_INT;
                else if (cls == CL_DIGIT) step_phase  = PH_INT;
                else                      step_status = ST_BAD_INT;
            end
            PH_INT, PH_AFTER_INT: begin
                if (phase_reg == PH_INT && cls inside {CL_ZERO, CL_DIGIT}) begin
                    step_phase = PH_INT;
                end else if (cls == CL_DOT) begin
                    step_phase = PH_DEC_FIRST;
                end else if (cls == CL_EXP) begin
                    step_phase = PH_EXP_SIGN;
                end else begin
                    step_status = ST_COMPLETE;
                end
            end
            PH_DEC_FIRST: begin
                if (cls inside {CL_ZERO, CL_DIGIT}) step_phase  = PH_DEC;
                else                                step_status = ST_BAD_DEC;
            end
            PH_DEC: begin
                if (cls inside {CL_ZERO, CL_DIGIT}) step_phase  = PH_DEC;
                else if (cls == CL_EXP)             step_phase  = PH_EXP_SIGN;
                else                                step_status = ST_COMPLETE;
            end
            PH_EXP_SIGN: begin
                if (cls inside {CL_MINUS, CL_PLUS})      step_phase  = PH_EXP_FIRST;
                else if (cls inside {CL_ZERO, CL_DIGIT}) step_phase  = PH_EXP;
                else                                     step_status = ST_BAD_EXP;
            end
            PH_EXP_FIRST: begin
                if (cls inside {CL_ZERO, CL_DIGIT}) step_phase  = PH_EXP;
                else                                step_status = ST_BAD_EXP;
            end
            PH_EXP: begin
                if (cls inside {CL_ZERO, CL_DIGIT}) step_phase  = PH_EXP;
                else                                step_status = ST_COMPLETE;
            end
            default: begin
                // sign phase, and any unused code
                if (cls == CL_MINUS)      step_phase  = PH_INT_FIRST;
                else if (cls == CL_ZERO)  step_phase  = PH_AFTER_INT;
                else if (cls == CL_DIGIT) step_phase  = PH_INT;
                else                      step_status = ST_BAD_INT;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        out_next   = out_reg;
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            valid_next = 1'b1;
            if (step_status == ST_CONSUMED) begin
                if (count_reg < COUNT_LIMIT) begin
                    count_next = count_reg + 8'd1;
                end
                phase_next            = step_phase;
                out_next.status       = ST_CONSUMED;
                out_next.token_byte   = q_req.text_byte;
                out_next.token_length = count_next;
            end else begin
                phase_next            = PH_SIGN;
                count_next            = 8'd0;
                out_next.status       = step_status;
                out_next.token_byte   = 8'd0;
                out_next.token_length = count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIGN;
            count_reg <= 8'd0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = valid_reg;
    assign m_req   = out_reg;

`ifndef SYNTH
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_LIMIT)
        else $error("token length above limit");
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && step_status != ST_CONSUMED)
            |=> (phase_reg == PH_SIGN && count_reg == 8'd0))
        else $error("parser did not restart after completion or error");
    a_eot_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && cls == CL_EOT) |-> (step_status != ST_CONSUMED))
        else $error("end of text consumed into token");
    a_consume_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && step_status == ST_CONSUMED && count_reg < COUNT_LIMIT)
            |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("consumed byte not counted");
`endif

endmodule

// ----- hw/rtl/json_number_token_recognizer_unit.sv -----
// Top level: JSON number token recognizer, classifier, queue and parser.
// Path: each request is classified into the queue, then parsed into the output register.
// Throughput: one byte per cycle sustained while the receiver does not stall.
// The two-entry queue lets input keep flowing during an output stall until it is full.
// Reset: aresetn synchronous, active low; clears phase, length count, queue, valid.
`timescale 1ns / 1ps

module json_number_token_recognizer_unit #(
    parameter int MAX_TOKEN_LENGTH = jnum_pkg::DEFAULT_MAX_TOKEN_LENGTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  jnum_pkg::in_req_t  s_req,
    // result request channel
    output logic               m_valid,
    input  logic               m_ready,
    output jnum_pkg::out_req_t m_req
);
    import jnum_pkg::*;

    cls_req_t cls_req;
    cls_req_t head_req;
    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;
    logic     push;

    // Input side stalls only when the queue holds two unparsed requests
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // Front: byte -> character class (zero, digit, sign, dot, exponent letter, end, other)
    jnum_front u_front (
        .in_req  (s_req),
        .cls_req (cls_req)
    );

    // Decoupling queue
    jnum_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_req  (cls_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_req  (head_req)
    );

    // Back: grammar state machine; pops whenever the output register frees up
    jnum_back #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_req   (head_req),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_req   (m_req)
    );

endmodule

// ----- tb/tb.sv -----
// Testbench for the JSON number token recognizer: directed table, random tokens, scoreboard.
`timescale 1ns / 1ps

module tb;

    import jnum_pkg::*;

    // Length count saturates at the smaller of the token limit and 255
    localparam int LEN_CAP = (DEFAULT_MAX_TOKEN_LENGTH > 255) ? 255 : DEFAULT_MAX_TOKEN_LENGTH;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_E_LO  = "e";
    localparam logic [7:0] CH_E_UP  = "E";

    // Random part: items per idling phase (four phases)
    localparam int ITEMS_PER_PHASE = 488;

    // One row of the directed table. When typed is set, res is the expected result;
    // otherwise the predictor supplies it.
    typedef struct packed {
        in_req_t  req;
        bit       typed;
        out_req_t res;
    } row_t;

    localparam int NUM_ROWS = 28;
    localparam row_t DIRECTED [0:NUM_ROWS-1] = '{
        '{'{1'b1, 8'h00}, 1'b1, '{ST_BAD_INT, 8'h00, 8'd0}},  // end of text right after reset
        '{'{1'b0, 8'hFF}, 1'b1, '{ST_BAD_INT, 8'h00, 8'd0}},  // top byte value
        '{'{1'b0, 8'h00}, 1'b1, '{ST_BAD_INT, 8'h00, 8'd0}},  // bottom byte value
        '{'{1'b0, "-"},   1'b0, '0},
        '{'{1'b1, 8'hFF}, 1'b1, '{ST_BAD_INT, 8'h00, 8'd1}},  // sign only, byte ignored
        '{'{1'b0, "0"},   1'b0, '0},
        '{'{1'b0, "5"},   1'b0, '0},                          // digit after leading zero
        '{'{1'b0, "0"},   1'b0, '0},
        '{'{1'b1, 8'h00}, 1'b0, '0},                          // end of text after integer
        '{'{1'b0, "9"},   1'b0, '0},
        '{'{1'b0, "."},   1'b0, '0},
        '{'{1'b1, 8'h00}, 1'b1, '{ST_BAD_DEC, 8'h00, 8'd2}},
        '{'{1'b0, "-"},   1'b0, '0},
        '{'{1'b0, "1"},   1'b0, '0},
        '{'{1'b0, "."},   1'b0, '0},
        '{'{1'b0, "a"},   1'b1, '{ST_BAD_DEC, 8'h00, 8'd3}},
        '{'{1'b0, "7"},   1'b0, '0},
        '{'{1'b0, "E"},   1'b0, '0},
        '{'{1'b1, 8'h00}, 1'b1, '{ST_BAD_EXP, 8'h00, 8'd2}},
        '{'{1'b0, "2"},   1'b0, '0},
        '{'{1'b0, "e"},   1'b0, '0},
        '{'{1'b0, "-"},   1'b0, '0},
        '{'{1'b1, 8'h00}, 1'b1, '{ST_BAD_EXP, 8'h00, 8'd3}},
        '{'{1'b0, "3"},   1'b0, '0},
        '{'{1'b0, "e"},   1'b0, '0},
        '{'{1'b0, "+"},   1'b0, '0},
        '{'{1'b0, "8"},   1'b0, '0},
        '{'{1'b0, ","},   1'b0, '0}                           // delimiter ends exponent
    };

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_req   = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_req_t m_req;

    // Predictor state
    logic [3:0] num_phase = PH_SIGN;
    logic [7:0] num_len   = 8'd0;

    out_req_t token_status_q [$];   // results still owed by the block
    in_req_t  text_q [$];           // text waiting to be sent
    int       mismatches   = 0;
    int       sender_idle  = 0;     // percent of cycles the sender holds off
    int       recv_stall   = 0;     // percent of cycles the receiver stalls
    bit       long_pending = 1'b0;

    always #5 aclk = ~aclk;

    json_number_token_recognizer_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_req   (m_req)
    );

    // Next status of the number lexer for one request; advances the predictor state.
    function automatic out_req_t lex_number_byte(input in_req_t req);
        logic [3:0] ph;
        logic [3:0] nxt;
        logic [2:0] st;
        logic [7:0] c;
        bit         dig;
        bit         exp_letter;
        out_req_t   r;
        ph         = (num_phase > PH_EXP) ? PH_SIGN : num_phase;
        nxt        = ph;
        st         = ST_CONSUMED;
        c          = req.text_byte;
        dig        = (c >= CH_ZERO) && (c <= CH_NINE);
        exp_letter = (c == CH_E_LO) || (c == CH_E_UP);
        if (req.end_of_text) begin
            case (ph)
                PH_INT, PH_AFTER_INT, PH_DEC, PH_EXP: st = ST_COMPLETE;
                PH_DEC_FIRST:                         st = ST_BAD_DEC;
                PH_EXP_SIGN, PH_EXP_FIRST:            st = ST_BAD_EXP;
                default:                              st = ST_BAD_INT;
            endcase
        end else begin
            case (ph)
                PH_SIGN, PH_INT_FIRST: begin
                    if (ph == PH_SIGN && c == CH_MINUS) nxt = PH_INT_FIRST;
                    else if (dig) nxt = (c == CH_ZERO) ? PH_AFTER_INT : PH_INT;
                    else st = ST_BAD_INT;
                end
                PH_INT, PH_AFTER_INT: begin
                    if (ph == PH_INT && dig) nxt = PH_INT;
                    else if (c == CH_DOT) nxt = PH_DEC_FIRST;
                    else if (exp_letter) nxt = PH_EXP_SIGN;
                    else st = ST_COMPLETE;
                end
                PH_DEC_FIRST: begin
                    if (dig) nxt = PH_DEC;
                    else st = ST_BAD_DEC;
                end
                PH_DEC: begin
                    if (dig) nxt = PH_DEC;
                    else if (exp_letter) nxt = PH_EXP_SIGN;
                    else st = ST_COMPLETE;
                end
                PH_EXP_SIGN: begin
                    if (c == CH_MINUS || c == CH_PLUS) nxt = PH_EXP_FIRST;
                    else if (dig) nxt = PH_EXP;
                    else st = ST_BAD_EXP;
                end
                PH_EXP_FIRST: begin
                    if (dig) nxt = PH_EXP;
                    else st = ST_BAD_EXP;
                end
                default: begin
                    if (dig) nxt = PH_EXP;
                    else st = ST_COMPLETE;
                end
            endcase
        end
        if (st == ST_CONSUMED) begin
            if (num_len < LEN_CAP) num_len = num_len + 8'd1;
            num_phase = nxt;
            r = '{ST_CONSUMED, c, num_len};
        end else begin
            // completion or error reports the count, then the token restarts
            r = '{st, 8'h00, num_len};
            num_phase = PH_SIGN;
            num_len   = 8'd0;
        end
        return r;
    endfunction

    // Offer one request; returns at the edge where it is accepted, with valid still high.
    task automatic send_request(input in_req_t req, input bit typed, input out_req_t res);
        out_req_t pred;
        while ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = lex_number_byte(req);
        token_status_q.push_back(typed ? res : pred);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (token_status_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_digit(input int lo);
        return CH_ZERO + 8'($urandom_range(9, lo));
    endfunction

    task automatic push_char(input logic [7:0] c);
        text_q.push_back('{1'b0, c});
    endtask

    // Queue one number, mostly well formed, sometimes cut short, then a terminator.
    task automatic queue_number_text();
        int start;
        int cut;
        int n;
        bit is_long;
        start   = text_q.size();
        is_long = long_pending || ($urandom_range(199) == 0);
        long_pending = 1'b0;
        if ($urandom_range(1)) push_char(CH_MINUS);
        if (!is_long && $urandom_range(3) == 0) begin
            push_char(CH_ZERO);
        end else begin
            push_char(rand_digit(1));
            n = is_long ? 256 + $urandom_range(30) : $urandom_range(5);
            repeat (n) push_char(rand_digit(0));
        end
        if ($urandom_range(1)) begin
            push_char(CH_DOT);
            repeat (1 + $urandom_range(3)) push_char(rand_digit(0));
        end
        if ($urandom_range(1)) begin
            push_char($urandom_range(1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(2))
                1: push_char(CH_PLUS);
                2: push_char(CH_MINUS);
                default: ;
            endcase
            repeat (1 + $urandom_range(2)) push_char(rand_digit(0));
        end
        // broken token: cut anywhere, possibly to nothing
        if (!is_long && $urandom_range(3) == 0) begin
            cut = start + $urandom_range(text_q.size() - start - 1);
            while (text_q.size() > cut) void'(text_q.pop_back());
        end
        case ($urandom_range(4))
            0, 1: text_q.push_back('{1'b1, 8'($urandom)});
            2:    text_q.push_back('{1'b0, 8'($urandom)});
            3: begin
                case ($urandom_range(3))
                    0: push_char(",");
                    1: push_char(" ");
                    2: push_char("]");
                    default: push_char("}");
                endcase
            end
            default: push_char(rand_digit(0));
        endcase
        // line noise between tokens
        if ($urandom_range(9) == 0)
            repeat (1 + $urandom_range(3)) text_q.push_back('{1'($urandom), 8'($urandom)});
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Result scoreboard: in-order compare against the oldest expectation
    always @(posedge aclk) begin
        out_req_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_status_q.size() == 0) begin
                $error("unexpected result request: status %0d byte %0d length %0d",
                       m_req.status, m_req.token_byte, m_req.token_length);
                mismatches++;
            end else begin
                want = token_status_q.pop_front();
                if (m_req.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_req.status);
                    mismatches++;
                end
                if (m_req.token_byte !== want.token_byte) begin
                    $error("token_byte: expected %0d, got %0d",
                           want.token_byte, m_req.token_byte);
                    mismatches++;
                end
                if (m_req.token_length !== want.token_length) begin
                    $error("token_length: expected %0d, got %0d",
                           want.token_length, m_req.token_length);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < NUM_ROWS; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);
        // sender waits for every owed result before the random part
        drain_results();

        // random tokens under four idling mixes: none, sender, receiver, both
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 68; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 68; end
                default: begin sender_idle = 36; recv_stall = 36; end
            endcase
            long_pending = (p == 0 || p == 3);   // saturate the length count
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                queue_number_text();
                while (text_q.size() != 0) begin
                    send_request(text_q.pop_front(), 1'b0, '0);
                    sent++;
                end
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
